// File: rtl/itf_pkg.sv
package itf_pkg;

    // Field widths of the transactions
    localparam int NUM_FIELD_W   = 64;
    localparam int CONV_W        = 3;
    localparam int WIDTH_FIELD_W = 7;
    localparam int PREC_W        = 7;
    localparam int CHAR_W        = 8;

    // Width of the internal length arithmetic (field width up to 127, sums up to 66)
    localparam int LEN_W = 8;

    // Conversion codes; unused codes behave as unsigned decimal
    localparam logic [CONV_W-1:0] CONV_SDEC = 3'd0;
    localparam logic [CONV_W-1:0] CONV_UDEC = 3'd1;
    localparam logic [CONV_W-1:0] CONV_OCT  = 3'd2;
    localparam logic [CONV_W-1:0] CONV_HEXL = 3'd3;
    localparam logic [CONV_W-1:0] CONV_HEXU = 3'd4;
    localparam logic [CONV_W-1:0] CONV_PTR  = 3'd5;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CHR_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CHR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;

    localparam logic [3:0] DIGIT_TEN = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BCD,
        ST_EXTRACT,
        ST_LENGTH,
        ST_EMIT
    } fmt_state_t;

    // One digit value (0..15) to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] letter_base;
        begin
            letter_base = upper ? CHR_UPPER_A : CHR_LOWER_A;
            if (d < DIGIT_TEN)
                digit_char = CHR_ZERO + {4'b0000, d};
            else
                digit_char = letter_base + {4'b0000, d - DIGIT_TEN};
        end
    endfunction

endpackage

// File: rtl/itf_in_if.sv
interface itf_in_if import itf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [NUM_FIELD_W-1:0]   number;
    logic [CONV_W-1:0]        conversion;
    logic [WIDTH_FIELD_W-1:0] field_width;
    logic signed [PREC_W-1:0] precision;
    logic                     zero_pad;
    logic                     plus_sign;
    logic                     space_sign;
    logic                     alternate;

    modport source
    (
        output valid, number, conversion, field_width, precision,
               zero_pad, plus_sign, space_sign, alternate,
        input  ready
    );

    modport sink
    (
        input  valid, number, conversion, field_width, precision,
               zero_pad, plus_sign, space_sign, alternate,
        output ready
    );
endinterface

// File: rtl/itf_out_if.sv
interface itf_out_if import itf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              empty_res;

    modport source
    (
        output valid, character, last, empty_res,
        input  ready
    );

    modport sink
    (
        input  valid, character, last, empty_res,
        output ready
    );
endinterface

// File: rtl/integer_to_text_formatter_unit.sv
// Integer to text formatter. Takes one number with a printf-style spec per
// request transaction and returns its ASCII text on the text channel, one
// character per transaction, most significant first, with last on the final
// character; an empty string is one transaction with empty_res and last set.
// One request is in work at a time. Decimal conversions first pass the value
// through a bit-serial BCD converter; then the digits are pulled one by one
// into a digit stack, with a final end test, the lengths are set, and one
// character leaves per cycle while the text receiver is ready. Octal and hex
// skip the BCD pass. The next request is taken as soon as the last character
// sits in the output register.
module integer_to_text_formatter_unit import itf_pkg::*;
#(
    parameter int MAX_LENGTH  = 64,
    parameter int NUMBER_BITS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    itf_in_if.sink    request,
    itf_out_if.source text
);

    localparam int DEC_DIGITS = (NUMBER_BITS * 1233) / 4096 + 1;
    localparam int OCT_DIGITS = (NUMBER_BITS + 2) / 3;
    localparam int SRC_W      = 4 * DEC_DIGITS;
    localparam int ND_W       = $clog2(OCT_DIGITS + 1);
    localparam int CNT_W      = $clog2(MAX_LENGTH + 1);

    fmt_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic [CONV_W-1:0]        conv_reg, conv_next;
    logic [WIDTH_FIELD_W-1:0] fw_reg, fw_next;
    logic [PREC_W-1:0]        prec_reg, prec_next;
    logic                     zp_reg, zp_next;
    logic                     pl_reg, pl_next;
    logic                     sp_reg, sp_next;
    logic                     alt_reg, alt_next;
    logic                     neg_reg, neg_next;
    logic                     mag_zero_reg, mag_zero_next;
    logic [SRC_W-1:0]         src_reg, src_next;
    logic [3:0]               dig_reg [OCT_DIGITS];
    logic [3:0]               dig_next [OCT_DIGITS];
    logic [ND_W-1:0]          nd_reg, nd_next;
    logic                     ns_reg, ns_next;
    logic [1:0]               pre_reg, pre_next;
    logic [CNT_W-1:0]         total_reg, total_next;
    logic [CNT_W-1:0]         dstart_reg, dstart_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CHAR_W-1:0]        char_reg, char_next;
    logic                     last_reg, last_next;
    logic                     empty_reg, empty_next;

    // BCD converter hookup
    logic                   bcd_start;
    logic                   bcd_done;
    logic [SRC_W-1:0]       bcd_value;
    logic [NUMBER_BITS-1:0] in_num;
    logic                   in_neg;
    logic [NUMBER_BITS-1:0] in_mag;
    logic                   in_decimal;

    itf_bcd_conv #(.NUMBER_BITS(NUMBER_BITS)) u_bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .value (in_mag),
        .done  (bcd_done),
        .bcd   (bcd_value)
    );

    // Magnitude of the incoming number
    assign in_num     = request.number[NUMBER_BITS-1:0];
    assign in_neg     = (request.conversion == CONV_SDEC) && in_num[NUMBER_BITS-1];
    assign in_mag     = in_neg ? (NUMBER_BITS'(0) - in_num) : in_num;
    assign in_decimal = (request.conversion != CONV_OCT) && (request.conversion != CONV_HEXL) &&
                        (request.conversion != CONV_HEXU) && (request.conversion != CONV_PTR);

    // Conversion class of the transaction in work
    logic is_oct, is_hex, is_ptr, upper;
    assign is_oct = (conv_reg == CONV_OCT);
    assign is_ptr = (conv_reg == CONV_PTR);
    assign is_hex = (conv_reg == CONV_HEXL) || (conv_reg == CONV_HEXU) || is_ptr;
    assign upper  = (conv_reg == CONV_HEXU);

    // Length arithmetic
    logic             nd_fix;
    logic [LEN_W-1:0] nd_e, prec_u, fw_u, b_len, sum_len, floor_len;
    logic [LEN_W-1:0] t1_len, t2_len, total_c;
    logic             ns_c, pad, empty_case;
    logic [1:0]       pre_c;

    always_comb
    begin
        nd_fix  = (nd_reg == '0) && (prec_reg != '0);
        nd_e    = nd_fix ? LEN_W'(1) : LEN_W'(nd_reg);
        prec_u  = LEN_W'(prec_reg[PREC_W-2:0]);
        fw_u    = LEN_W'(fw_reg);
        b_len   = (!prec_reg[PREC_W-1] && (prec_u > nd_e)) ? prec_u : nd_e;
        ns_c    = (conv_reg == CONV_SDEC) && (neg_reg || sp_reg || pl_reg);
        pre_c   = 2'd0;
        if (alt_reg)
        begin
            if (is_ptr || (is_hex && !mag_zero_reg))
                pre_c = 2'd2;
            else if (is_oct && ((b_len == '0) || ((b_len == nd_e) && !mag_zero_reg)))
                pre_c = 2'd1;
        end
        sum_len    = LEN_W'(ns_c) + LEN_W'(pre_c) + b_len;
        floor_len  = LEN_W'(ns_c) + LEN_W'(pre_c) + nd_e;
        pad        = zp_reg && (prec_reg[PREC_W-1] || (fw_u > prec_u)) &&
                     (fw_u > nd_e) && (fw_u > sum_len);
        t1_len     = pad ? fw_u : sum_len;
        t2_len     = (t1_len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : t1_len;
        empty_case = mag_zero_reg && (prec_reg == '0) && !is_oct && !is_ptr;
        if (empty_case)
            total_c = '0;
        else if (t2_len < floor_len)
            total_c = floor_len;
        else
            total_c = t2_len;
    end

    // Character at the current output position
    logic [CHAR_W-1:0] sign_char, char_c;
    logic [LEN_W-1:0]  idx_e;
    logic              pop;

    always_comb
    begin
        idx_e = LEN_W'(idx_reg);
        if (neg_reg)
            sign_char = CHR_MINUS;
        else if (sp_reg)
            sign_char = CHR_SPACE;
        else
            sign_char = CHR_PLUS;
        pop = 1'b0;
        if (idx_e < LEN_W'(ns_reg))
            char_c = sign_char;
        else if (idx_e < LEN_W'(ns_reg) + LEN_W'(pre_reg))
            char_c = (idx_e == LEN_W'(ns_reg)) ? CHR_ZERO : (upper ? CHR_UPPER_X : CHR_LOWER_X);
        else if (idx_reg < dstart_reg)
            char_c = CHR_ZERO;
        else
        begin
            char_c = digit_char(dig_reg[0], upper);
            pop    = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !text.ready;
        conv_next      = conv_reg;
        fw_next        = fw_reg;
        prec_next      = prec_reg;
        zp_next        = zp_reg;
        pl_next        = pl_reg;
        sp_next        = sp_reg;
        alt_next       = alt_reg;
        neg_next       = neg_reg;
        mag_zero_next  = mag_zero_reg;
        src_next       = src_reg;
        dig_next       = dig_reg;
        nd_next        = nd_reg;
        ns_next        = ns_reg;
        pre_next       = pre_reg;
        total_next     = total_reg;
        dstart_next    = dstart_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        bcd_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    conv_next     = request.conversion;
                    fw_next       = request.field_width;
                    prec_next     = request.precision;
                    zp_next       = request.zero_pad;
                    pl_next       = request.plus_sign;
                    sp_next       = request.space_sign;
                    alt_next      = request.alternate;
                    neg_next      = in_neg;
                    mag_zero_next = (in_mag == '0);
                    nd_next       = '0;
                    src_next      = SRC_W'(in_mag);
                    if (in_decimal)
                    begin
                        bcd_start  = 1'b1;
                        state_next = ST_BCD;
                    end
                    else
                        state_next = ST_EXTRACT;
                end
            end

            ST_BCD:
            begin
                if (bcd_done)
                begin
                    src_next   = bcd_value;
                    state_next = ST_EXTRACT;
                end
            end

            // Pull digits least significant first onto the stack
            ST_EXTRACT:
            begin
                if (src_reg != '0)
                begin
                    dig_next[0] = is_oct ? {1'b0, src_reg[2:0]} : src_reg[3:0];
                    for (int k = 1; k < OCT_DIGITS; k++)
                        dig_next[k] = dig_reg[k-1];
                    src_next = is_oct ? (src_reg >> 3) : (src_reg >> 4);
                    nd_next  = nd_reg + 1'b1;
                end
                else
                    state_next = ST_LENGTH;
            end

            ST_LENGTH:
            begin
                if (nd_fix)
                    dig_next[0] = 4'd0;
                ns_next     = ns_c;
                pre_next    = pre_c;
                total_next  = total_c[CNT_W-1:0];
                dstart_next = total_c[CNT_W-1:0] - nd_e[CNT_W-1:0];
                idx_next    = '0;
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || text.ready)
                begin
                    out_valid_next = 1'b1;
                    if (total_reg == '0)
                    begin
                        char_next  = CHR_NUL;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        char_next  = char_c;
                        last_next  = (idx_reg == total_reg - 1'b1);
                        empty_next = 1'b0;
                        idx_next   = idx_reg + 1'b1;
                        if (pop)
                        begin
                            for (int k = 0; k < OCT_DIGITS - 1; k++)
                                dig_next[k] = dig_reg[k+1];
                            dig_next[OCT_DIGITS-1] = 4'd0;
                        end
                        if (idx_reg == total_reg - 1'b1)
                            state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        conv_reg     <= conv_next;
        fw_reg       <= fw_next;
        prec_reg     <= prec_next;
        zp_reg       <= zp_next;
        pl_reg       <= pl_next;
        sp_reg       <= sp_next;
        alt_reg      <= alt_next;
        neg_reg      <= neg_next;
        mag_zero_reg <= mag_zero_next;
        src_reg      <= src_next;
        dig_reg      <= dig_next;
        nd_reg       <= nd_next;
        ns_reg       <= ns_next;
        pre_reg      <= pre_next;
        total_reg    <= total_next;
        dstart_reg   <= dstart_next;
        idx_reg      <= idx_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
    end

    // Channel outputs
    assign request.ready  = (state_reg == ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;
    assign text.empty_res = empty_reg;

endmodule

// File: rtl/itf_bcd_conv.sv
// Iterative binary to BCD converter (shift and add-3), one bit per cycle
module itf_bcd_conv import itf_pkg::*;
#(
    parameter int NUMBER_BITS = 64,
    localparam int DEC_DIGITS = (NUMBER_BITS * 1233) / 4096 + 1,
    localparam int BCD_W      = 4 * DEC_DIGITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUMBER_BITS-1:0] value,
    output logic                   done,
    output logic [BCD_W-1:0]       bcd
);

    localparam int CW = $clog2(NUMBER_BITS + 1);

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [NUMBER_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int k = 0; k < DEC_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
    end

    // Step control
    always_comb
    begin
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(NUMBER_BITS);
            bin_next = value;
            bcd_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            bin_next  = {bin_reg[NUMBER_BITS-2:0], 1'b0};
            bcd_next  = {adj[BCD_W-2:0], bin_reg[NUMBER_BITS-1]};
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import itf_pkg::*;

    localparam int TEXT_MAX     = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int END_SETTLE   = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 45;

    // Spare conversion codes, formatted as unsigned decimal
    localparam logic [CONV_W-1:0] CONV_SPARE_A = 3'd6;
    localparam logic [CONV_W-1:0] CONV_SPARE_B = 3'd7;

    typedef struct {
        logic [NUM_FIELD_W-1:0]   number;
        logic [CONV_W-1:0]        conversion;
        logic [WIDTH_FIELD_W-1:0] field_width;
        logic signed [PREC_W-1:0] precision;
        logic                     zero_pad;
        logic                     plus_sign;
        logic                     space_sign;
        logic                     alternate;
    } fmt_request_t;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              empty_res;
    } text_char_t;

    logic clk;
    logic rst_n;

    itf_in_if  request_if ();
    itf_out_if text_if ();

    integer_to_text_formatter_unit #(
        .MAX_LENGTH  (TEXT_MAX),
        .NUMBER_BITS (NUM_FIELD_W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .text    (text_if)
    );

    // Characters still owed by the block, oldest first
    text_char_t expected_text[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int requests_sent;
    int chars_checked = 0;
    int strings_checked = 0;
    int empty_checked = 0;
    int mismatch_count = 0;

    // Clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d characters still owed",
                   cycle_count, expected_text.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Text receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_if.ready <= 1'b0;
        end
        else if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
            text_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            text_if.ready <= 1'b0;
        end
        else
        begin
            text_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Expected text of one request, appended to expected_text
    function automatic void predict_text(input fmt_request_t r);
        logic [NUM_FIELD_W-1:0] mag;
        logic [NUM_FIELD_W-1:0] rest;
        logic [3:0]             digits [0:31];
        logic [CHAR_W-1:0]      text_buf [0:TEXT_MAX-1];
        logic [CHAR_W-1:0]      sign_chr;
        logic                   neg;
        logic                   upper;
        text_char_t             c;
        int radix, prec, fw, n_dig, body, prefix_len, sign_len, total, pos, i;
        begin
            radix = 10;
            if (r.conversion == CONV_OCT)
                radix = 8;
            else if (r.conversion == CONV_HEXL || r.conversion == CONV_HEXU ||
                     r.conversion == CONV_PTR)
                radix = 16;
            upper = (r.conversion == CONV_HEXU);
            neg = (r.conversion == CONV_SDEC) && r.number[NUM_FIELD_W-1];
            mag = neg ? -r.number : r.number;
            prec = int'(r.precision);
            fw = int'(r.field_width);
            total = 0;
            n_dig = 0;
            sign_len = 0;
            prefix_len = 0;
            sign_chr = CHR_NUL;

            // Zero at precision zero prints nothing, bar octal and pointer
            if (!(mag == 0 && prec == 0 && r.conversion != CONV_OCT &&
                  r.conversion != CONV_PTR))
            begin
                if (r.conversion == CONV_SDEC)
                begin
                    if (neg)
                        sign_chr = CHR_MINUS;
                    else if (r.space_sign)
                        sign_chr = CHR_SPACE;
                    else if (r.plus_sign)
                        sign_chr = CHR_PLUS;
                end
                sign_len = (sign_chr != CHR_NUL) ? 1 : 0;

                rest = mag;
                while (rest != 0)
                begin
                    digits[n_dig] = 4'(rest % radix);
                    rest = rest / radix;
                    n_dig++;
                end
                if (n_dig == 0 && prec != 0)
                begin
                    digits[0] = 4'd0;
                    n_dig = 1;
                end
                body = (prec > n_dig) ? prec : n_dig;

                // Alternate-form prefix
                if (r.alternate)
                begin
                    if (r.conversion == CONV_PTR ||
                        ((r.conversion == CONV_HEXL || r.conversion == CONV_HEXU) && mag != 0))
                        prefix_len = 2;
                    else if (r.conversion == CONV_OCT)
                        prefix_len = (body == 0 || (body == n_dig && mag != 0)) ? 1 : 0;
                end

                // Lengths: zero padding, clamp, never below the bare text
                total = sign_len + prefix_len + body;
                if (r.zero_pad && fw > prec && fw > n_dig && fw > total)
                    total = fw;
                if (total > TEXT_MAX)
                    total = TEXT_MAX;
                if (total < sign_len + prefix_len + n_dig)
                    total = sign_len + prefix_len + n_dig;

                for (i = 0; i < total; i++)
                    text_buf[i] = CHR_ZERO;
                pos = total;
                for (i = 0; i < n_dig; i++)
                begin
                    pos--;
                    if (digits[i] < 10)
                        text_buf[pos] = CHR_ZERO + CHAR_W'(digits[i]);
                    else
                        text_buf[pos] = (upper ? CHR_UPPER_A : CHR_LOWER_A) +
                                        CHAR_W'(digits[i] - 10);
                end
                if (prefix_len == 2)
                    text_buf[sign_len + 1] = upper ? CHR_UPPER_X : CHR_LOWER_X;
                if (sign_len == 1)
                    text_buf[0] = sign_chr;
            end

            if (total == 0)
            begin
                c.character = CHR_NUL;
                c.last = 1'b1;
                c.empty_res = 1'b1;
                expected_text.push_back(c);
            end
            else
            begin
                for (i = 0; i < total; i++)
                begin
                    c.character = text_buf[i];
                    c.last = (i == total - 1);
                    c.empty_res = 1'b0;
                    expected_text.push_back(c);
                end
            end
        end
    endfunction

    function automatic fmt_request_t make_request(input logic [NUM_FIELD_W-1:0] number,
                                                  input logic [CONV_W-1:0] conversion,
                                                  input int field_width, input int precision,
                                                  input int zp, input int pl, input int sp,
                                                  input int alt);
        fmt_request_t r;
        begin
            r.number = number;
            r.conversion = conversion;
            r.field_width = WIDTH_FIELD_W'(field_width);
            r.precision = PREC_W'(precision);
            r.zero_pad = 1'(zp);
            r.plus_sign = 1'(pl);
            r.space_sign = 1'(sp);
            r.alternate = 1'(alt);
            return r;
        end
    endfunction

    // Mostly short strings; wide fields and raw precisions now and then
    function automatic fmt_request_t random_request();
        fmt_request_t r;
        begin
            case ($urandom_range(5))
                0: r.number = NUM_FIELD_W'($urandom_range(15));
                1: r.number = {$urandom, $urandom};
                2: r.number = {$urandom, $urandom} >> $urandom_range(63);
                3: r.number = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
                4: r.number = ~({$urandom, $urandom} >> $urandom_range(63));
                default: r.number = '0;
            endcase
            if ($urandom_range(9) == 0)
                r.conversion = CONV_W'($urandom_range(7, 6));
            else
                r.conversion = CONV_W'($urandom_range(5));
            if ($urandom_range(9) == 0)
                r.field_width = WIDTH_FIELD_W'($urandom_range(127));
            else
                r.field_width = WIDTH_FIELD_W'($urandom_range(24));
            case ($urandom_range(5))
                0: r.precision = PREC_W'(-1);
                1: r.precision = '0;
                2, 3: r.precision = PREC_W'($urandom_range(20));
                4: r.precision = PREC_W'($urandom_range(8));
                default: r.precision = PREC_W'($urandom);
            endcase
            r.zero_pad = 1'($urandom_range(1));
            r.plus_sign = 1'($urandom_range(1));
            r.space_sign = 1'($urandom_range(1));
            r.alternate = 1'($urandom_range(1));
            return r;
        end
    endfunction

    // Offer one request; returns once the block has taken it
    task automatic send_request(input fmt_request_t r);
        begin
            if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            begin
                request_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < send_idle_pct);
            end
            request_if.valid       <= 1'b1;
            request_if.number      <= r.number;
            request_if.conversion  <= r.conversion;
            request_if.field_width <= r.field_width;
            request_if.precision   <= r.precision;
            request_if.zero_pad    <= r.zero_pad;
            request_if.plus_sign   <= r.plus_sign;
            request_if.space_sign  <= r.space_sign;
            request_if.alternate   <= r.alternate;
            do
                @(posedge clk);
            while (!request_if.ready);
            predict_text(r);
            requests_sent++;
        end
    endtask

    // Sender goes quiet until every owed character has come back
    task automatic wait_text_drained();
        begin
            request_if.valid <= 1'b0;
            while (expected_text.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic run_random(input int n_items, input int idle_pct, input int stall_pct);
        int i;
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            for (i = 0; i < n_items; i++)
                send_request(random_request());
        end
    endtask

    // Extremes, every conversion and the special cases
    task automatic test_directed();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            send_request(make_request(64'd0, CONV_SDEC, 0, -1, 0, 0, 0, 0));
            // empty zero ignores flags and width
            send_request(make_request(64'd0, CONV_SDEC, 10, 0, 1, 1, 0, 1));
            send_request(make_request(64'h8000_0000_0000_0000, CONV_SDEC, 0, -1, 0, 0, 0, 0));
            send_request(make_request(64'h7FFF_FFFF_FFFF_FFFF, CONV_SDEC, 0, -1, 0, 1, 0, 0));
            // space beats plus
            send_request(make_request(64'd42, CONV_SDEC, 0, -1, 0, 1, 1, 0));
            send_request(make_request(-64'd5, CONV_SDEC, 8, -1, 1, 0, 0, 0));
            send_request(make_request('1, CONV_UDEC, 0, -1, 0, 1, 1, 1));
            // octal zero, precision zero: prefix alone, or nothing
            send_request(make_request(64'd0, CONV_OCT, 0, 0, 0, 0, 0, 1));
            send_request(make_request(64'd0, CONV_OCT, 0, 0, 0, 0, 0, 0));
            send_request(make_request(64'd8, CONV_OCT, 0, -1, 0, 0, 0, 1));
            send_request(make_request(64'd8, CONV_OCT, 0, 5, 0, 0, 0, 1));
            send_request(make_request('1, CONV_OCT, 0, -1, 0, 0, 0, 1));
            send_request(make_request(64'd0, CONV_HEXL, 0, -1, 0, 0, 0, 1));
            send_request(make_request(64'hDEAD_BEEF, CONV_HEXL, 12, -1, 1, 0, 0, 1));
            send_request(make_request('1, CONV_HEXU, 0, -1, 0, 0, 0, 1));
            send_request(make_request(64'd0, CONV_HEXL, 0, 0, 0, 0, 0, 1));
            // pointer zero, precision zero
            send_request(make_request(64'd0, CONV_PTR, 0, 0, 0, 0, 0, 0));
            send_request(make_request(64'd0, CONV_PTR, 6, 0, 1, 0, 0, 1));
            send_request(make_request(64'h1234, CONV_PTR, 0, -1, 0, 0, 0, 1));
            // long lengths, clamped
            send_request(make_request(64'd7, CONV_UDEC, 0, 63, 0, 0, 0, 0));
            send_request(make_request(64'd1, CONV_HEXL, 0, 63, 0, 0, 0, 1));
            send_request(make_request('1, CONV_SDEC, 127, -1, 1, 1, 0, 0));
            send_request(make_request(64'd123, CONV_SPARE_A, 0, -1, 0, 1, 0, 1));
            send_request(make_request('1, CONV_SPARE_B, 0, -1, 0, 1, 1, 0));
            // any negative precision means none
            send_request(make_request(64'd0, CONV_UDEC, 0, -64, 0, 0, 0, 0));
            send_request(make_request(64'd5, CONV_UDEC, 6, 6, 1, 0, 0, 0));
            wait_text_drained();
        end
    endtask

    task automatic test_random_no_idle();
        begin
            run_random(RANDOM_ITEMS, 0, 0);
        end
    endtask

    task automatic test_random_sender_idle();
        begin
            run_random(RANDOM_ITEMS, 59, 0);
        end
    endtask

    task automatic test_random_receiver_stall();
        begin
            run_random(RANDOM_ITEMS, 0, 59);
        end
    endtask

    task automatic test_random_both_idle();
        begin
            run_random(RANDOM_ITEMS, 34, 34);
        end
    endtask

    // Receiver holds off while requests keep coming, so the block backs up
    task automatic test_long_backpressure();
        begin
            wait_text_drained();
            hold_request++;
            run_random(10, 0, 0);
            wait_text_drained();
        end
    endtask

    // Sender pauses mid-stream until all text is back
    task automatic test_drain_pause();
        begin
            run_random(8, 20, 20);
            wait_text_drained();
            run_random(8, 20, 20);
            wait_text_drained();
        end
    endtask

    // Compare every accepted character with the oldest expectation
    always @(posedge clk)
    begin : check_text
        text_char_t want;
        if (rst_n && text_if.valid && text_if.ready)
        begin
            chars_checked++;
            if (text_if.last)
                strings_checked++;
            if (text_if.empty_res)
                empty_checked++;
            if (expected_text.size() == 0)
            begin
                $error("unexpected text transaction: character %h last %b empty_res %b",
                       text_if.character, text_if.last, text_if.empty_res);
                mismatch_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_if.character !== want.character)
                begin
                    $error("character: expected %h, actual %h",
                           want.character, text_if.character);
                    mismatch_count++;
                end
                if (text_if.last !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, text_if.last);
                    mismatch_count++;
                end
                if (text_if.empty_res !== want.empty_res)
                begin
                    $error("empty_res: expected %b, actual %b",
                           want.empty_res, text_if.empty_res);
                    mismatch_count++;
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        requests_sent = 0;
        request_if.valid = 1'b0;
        request_if.number = '0;
        request_if.conversion = CONV_SDEC;
        request_if.field_width = '0;
        request_if.precision = '0;
        request_if.zero_pad = 1'b0;
        request_if.plus_sign = 1'b0;
        request_if.space_sign = 1'b0;
        request_if.alternate = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_long_backpressure();
        test_drain_pause();

        wait_text_drained();
        repeat (END_SETTLE) @(posedge clk);

        $display("Sent %0d requests; checked %0d strings (%0d empty), %0d characters.",
                 requests_sent, strings_checked, empty_checked, chars_checked);
        $display("Covered all conversions, flags, clamped lengths, idle sides and a long stall.");
        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
